// File: design/assert_macros.svh
// Assertion macros used by the core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/smm_pkg.sv
// Shared types, codes and constants of the sparse matrix multiply core.
package smm_pkg;

  localparam int MAX_DIM_DEF = 32;
  localparam int MAX_NNZ_DEF = 256;

  localparam int KIND_W    = 3;
  localparam int IDX_W     = 5;
  localparam int VAL_W     = 16;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 2;
  localparam int PROD_W    = 32;
  localparam int ACC_W     = 40;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A  = 3'd0,
    KIND_LOAD_B  = 3'd1,
    KIND_COMPUTE = 3'd2,
    KIND_READ    = 3'd3,
    KIND_CLEAR   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic             go;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } ld_req_t;

  typedef struct packed {
    logic    done;
    status_t status;
  } ld_rsp_t;

endpackage

// File: design/smm_csc_store.sv
// Column-compressed storage of one sparse matrix: loading, pointer lookup, entry reads.
module smm_csc_store #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF,
  parameter int MAX_NNZ = smm_pkg::MAX_NNZ_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smm_pkg::ld_req_t                    ld_req,
  output smm_pkg::ld_rsp_t                    ld_rsp,
  input  logic                                clr,
  input  logic [$clog2(MAX_DIM+1)-1:0]        rows_lim,
  input  logic [$clog2(MAX_DIM+1)-1:0]        cols_lim,
  input  logic [$clog2(MAX_DIM+1)-1:0]        ptr_col,
  output logic [$clog2(MAX_NNZ+1)-1:0]        ptr_lo,
  output logic [$clog2(MAX_NNZ+1)-1:0]        ptr_hi,
  input  logic [$clog2(MAX_NNZ)-1:0]          ent_addr,
  output logic [$clog2(MAX_DIM)-1:0]          ent_row,
  output logic signed [smm_pkg::VAL_W-1:0]    ent_value
);
  import smm_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int RW = $clog2(MAX_DIM);
  localparam int CW = $clog2(MAX_NNZ + 1);
  localparam int AW = $clog2(MAX_NNZ);

  typedef enum logic [1:0] {
    SS_IDLE = 2'b01,
    SS_FILL = 2'b10
  } sst_t;

  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_COUNT = 2'd1,
    SRC_MEM   = 2'd2
  } ptr_src_t;

  sst_t            state_r;
  logic [CW-1:0]   cnt_r;
  logic [RW-1:0]   last_r;
  logic [RW-1:0]   fill_ptr_r;
  logic [RW-1:0]   fill_end_r;
  logic [CW-1:0]   fill_val_r;
  logic            done_r;
  status_t         status_r;

  logic [RW-1:0]    row_mem [MAX_NNZ];
  logic [VAL_W-1:0] val_mem [MAX_NNZ];
  logic [CW-1:0]    ptr_mem [MAX_DIM];

  logic [CW-1:0]    ptr_rd_lo_r;
  logic [CW-1:0]    ptr_rd_hi_r;
  ptr_src_t         lo_src_r;
  ptr_src_t         hi_src_r;
  logic [RW-1:0]    ent_row_r;
  logic [VAL_W-1:0] ent_val_r;

  status_t         ld_status;
  logic [RW-1:0]   ld_col;
  logic            ld_write;
  logic [DW-1:0]   ptr_col_hi;

  assign ld_col = RW'(ld_req.col);

  always_comb begin
    if (32'(ld_req.row) >= 32'(rows_lim) || 32'(ld_req.col) >= 32'(cols_lim)) begin
      ld_status = ST_RANGE;
    end else if (32'(ld_req.col) < 32'(last_r)) begin
      ld_status = ST_ORDER;
    end else if (cnt_r == CW'(MAX_NNZ)) begin
      ld_status = ST_FULL;
    end else begin
      ld_status = ST_OK;
    end
  end

  assign ld_write = (state_r == SS_IDLE) && ld_req.go && !clr && (ld_status == ST_OK);

  // Pointers of columns beyond the last loaded one all equal the count, so
  // only columns up to the last one are kept; the gap is filled on a jump.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SS_IDLE;
      cnt_r    <= '0;
      last_r   <= '0;
      done_r   <= 1'b0;
      status_r <= ST_OK;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        SS_IDLE: begin
          if (clr) begin
            cnt_r  <= '0;
            last_r <= '0;
          end else if (ld_req.go) begin
            status_r <= ld_status;
            if (ld_status == ST_OK) begin
              cnt_r  <= cnt_r + CW'(1);
              last_r <= ld_col;
              if (ld_col > last_r) begin
                fill_ptr_r <= last_r + RW'(1);
                fill_end_r <= ld_col;
                fill_val_r <= cnt_r;
                state_r    <= SS_FILL;
              end else begin
                done_r <= 1'b1;
              end
            end else begin
              done_r <= 1'b1;
            end
          end
        end
        SS_FILL: begin
          if (fill_ptr_r == fill_end_r) begin
            done_r  <= 1'b1;
            state_r <= SS_IDLE;
          end else begin
            fill_ptr_r <= fill_ptr_r + RW'(1);
          end
        end
        default: state_r <= SS_IDLE;
      endcase
    end
  end

  assign ptr_col_hi = ptr_col + DW'(1);

  always_ff @(posedge clk) begin
    if (ld_write) begin
      row_mem[cnt_r[AW-1:0]] <= RW'(ld_req.row);
      val_mem[cnt_r[AW-1:0]] <= ld_req.value;
    end
    if (state_r == SS_FILL) begin
      ptr_mem[fill_ptr_r] <= fill_val_r;
    end
    ptr_rd_lo_r <= ptr_mem[ptr_col[RW-1:0]];
    ptr_rd_hi_r <= ptr_mem[ptr_col_hi[RW-1:0]];
    ent_row_r   <= row_mem[ent_addr];
    ent_val_r   <= val_mem[ent_addr];
    if (ptr_col == '0) begin
      lo_src_r <= SRC_ZERO;
    end else if (32'(ptr_col) > 32'(last_r)) begin
      lo_src_r <= SRC_COUNT;
    end else begin
      lo_src_r <= SRC_MEM;
    end
    if (32'(ptr_col_hi) > 32'(last_r)) begin
      hi_src_r <= SRC_COUNT;
    end else begin
      hi_src_r <= SRC_MEM;
    end
  end

  always_comb begin
    unique case (lo_src_r)
      SRC_ZERO:  ptr_lo = '0;
      SRC_COUNT: ptr_lo = cnt_r;
      default:   ptr_lo = ptr_rd_lo_r;
    endcase
    unique case (hi_src_r)
      SRC_COUNT: ptr_hi = cnt_r;
      default:   ptr_hi = ptr_rd_hi_r;
    endcase
  end

  assign ent_row       = ent_row_r;
  assign ent_value     = $signed(ent_val_r);
  assign ld_rsp.done   = done_r;
  assign ld_rsp.status = status_r;

endmodule

// File: design/sparse_csc_matrix_multiply_core.sv
// Sparse matrix multiply core: two column-compressed matrices and a dense product store.
// Usage:
// One request enters on in_valid/in_ready and gives exactly one result on
// out_valid/out_ready. in_kind selects loading an entry of A or B, computing
// C = A*B, reading one entry of C, or clearing both matrices.
// The block takes one request at a time: in_ready is high only when idle,
// and the result is held in output registers until out_ready takes it.
// A load stays busy while its store fills in the column pointers skipped when the
// column jumps ahead. A read in range reads the product store first; a read out of
// range, a clear or an unused kind goes straight to its result. A compute first
// sweeps the product store to zero, then walks each column of B and each of its
// entries whose row is in range and, for each, every entry of A in the matching
// column, accumulating the product when the row of A is in range; the single
// multiplier and the single write port of the product store take the products
// one at a time.
// Configuration writes on cfg_we are taken in any cycle but must only be made
// while the block is idle. Reset sets all three dimensions to 32 and empties
// both matrices; the product store is then swept to zero with in_ready low,
// and is cleared again by every compute request.
// While the receiver stalls the result simply waits and no new request is taken.
module sparse_csc_matrix_multiply_core #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF,
  parameter int MAX_NNZ = smm_pkg::MAX_NNZ_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [smm_pkg::KIND_W-1:0]           in_kind,
  input  logic [smm_pkg::IDX_W-1:0]            in_row,
  input  logic [smm_pkg::IDX_W-1:0]            in_col,
  input  logic signed [smm_pkg::VAL_W-1:0]     in_entry_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [smm_pkg::STATUS_W-1:0]         out_status,
  output logic signed [smm_pkg::ACC_W-1:0]     out_product_value,
  input  logic                                 cfg_we,
  input  logic [smm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [smm_pkg::CFG_W-1:0]            cfg_data
);
  import smm_pkg::*;

  `include "assert_macros.svh"

  localparam int DW       = $clog2(MAX_DIM + 1);
  localparam int RW       = $clog2(MAX_DIM);
  localparam int CW       = $clog2(MAX_NNZ + 1);
  localparam int AW       = $clog2(MAX_NNZ);
  localparam int PS_DEPTH = MAX_DIM * MAX_DIM;
  localparam int PS_AW    = $clog2(PS_DEPTH);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LOAD  = 14'b00000000000010,
    S_PCLR  = 14'b00000000000100,
    S_BLOOK = 14'b00000000001000,
    S_BPTR  = 14'b00000000010000,
    S_BENT  = 14'b00000000100000,
    S_BCHK  = 14'b00000001000000,
    S_APTR  = 14'b00000010000000,
    S_ARD   = 14'b00000100000000,
    S_ACHK  = 14'b00001000000000,
    S_ACC   = 14'b00010000000000,
    S_READ  = 14'b00100000000000,
    S_OUT   = 14'b01000000000000,
    S_INIT  = 14'b10000000000000
  } state_t;

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] a_rows_r, inner_dim_r, b_cols_r;
  logic [DW-1:0]    m_eff, kd_eff, n_eff;

  logic [DW-1:0]            j_r;
  logic [CW-1:0]            kx_r, be_r, ix_r, ae_r;
  logic signed [VAL_W-1:0]  bv_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [PS_AW-1:0]         ps_waddr_r, clr_addr_r;
  logic [ACC_W-1:0]         ps_rd_r;
  status_t                  out_status_r;
  logic [ACC_W-1:0]         out_value_r;

  logic [ACC_W-1:0] ps_mem [PS_DEPTH];
  logic [PS_AW-1:0] ps_raddr;

  ld_req_t a_req, b_req;
  ld_rsp_t a_rsp, b_rsp;
  logic    mat_clr;
  logic    rd_bad;

  logic [CW-1:0]           a_ptr_lo, a_ptr_hi, b_ptr_lo, b_ptr_hi;
  logic [RW-1:0]           a_ent_row, b_ent_row;
  logic signed [VAL_W-1:0] a_ent_value, b_ent_value;

  assign m_eff  = eff_dim(a_rows_r);
  assign kd_eff = eff_dim(inner_dim_r);
  assign n_eff  = eff_dim(b_cols_r);

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = (state_r == S_OUT);
  assign out_status        = out_status_r;
  assign out_product_value = $signed(out_value_r);

  assign rd_bad = (32'(in_row) >= 32'(m_eff)) || (32'(in_col) >= 32'(n_eff));

  always_comb begin
    a_req.go    = (state_r == S_IDLE) && in_valid && (in_kind == KIND_LOAD_A);
    a_req.row   = in_row;
    a_req.col   = in_col;
    a_req.value = in_entry_value;
    b_req.go    = (state_r == S_IDLE) && in_valid && (in_kind == KIND_LOAD_B);
    b_req.row   = in_row;
    b_req.col   = in_col;
    b_req.value = in_entry_value;
  end

  assign mat_clr = (state_r == S_IDLE) && in_valid && (in_kind == KIND_CLEAR);

  smm_csc_store #(.MAX_DIM(MAX_DIM), .MAX_NNZ(MAX_NNZ)) u_store_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_req    (a_req),
    .ld_rsp    (a_rsp),
    .clr       (mat_clr),
    .rows_lim  (m_eff),
    .cols_lim  (kd_eff),
    .ptr_col   (DW'(b_ent_row)),
    .ptr_lo    (a_ptr_lo),
    .ptr_hi    (a_ptr_hi),
    .ent_addr  (ix_r[AW-1:0]),
    .ent_row   (a_ent_row),
    .ent_value (a_ent_value)
  );

  smm_csc_store #(.MAX_DIM(MAX_DIM), .MAX_NNZ(MAX_NNZ)) u_store_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_req    (b_req),
    .ld_rsp    (b_rsp),
    .clr       (mat_clr),
    .rows_lim  (kd_eff),
    .cols_lim  (n_eff),
    .ptr_col   (j_r),
    .ptr_lo    (b_ptr_lo),
    .ptr_hi    (b_ptr_hi),
    .ent_addr  (kx_r[AW-1:0]),
    .ent_row   (b_ent_row),
    .ent_value (b_ent_value)
  );

  // The product store is read either for a request or for the accumulate step.
  always_comb begin
    if (state_r == S_ACHK) begin
      ps_raddr = PS_AW'(32'(a_ent_row) * MAX_DIM + 32'(j_r));
    end else begin
      ps_raddr = PS_AW'(32'(in_row) * MAX_DIM + 32'(in_col));
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:  if (clr_addr_r == PS_AW'(PS_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_LOAD_A, KIND_LOAD_B: state_nxt = S_LOAD;
            KIND_COMPUTE:             state_nxt = S_PCLR;
            KIND_READ:                state_nxt = rd_bad ? S_OUT : S_READ;
            default:                  state_nxt = S_OUT;
          endcase
        end
      end
      S_LOAD:  if (a_rsp.done || b_rsp.done) state_nxt = S_OUT;
      S_PCLR:  if (clr_addr_r == PS_AW'(PS_DEPTH - 1)) state_nxt = S_BLOOK;
      S_BLOOK: state_nxt = (j_r == n_eff) ? S_OUT : S_BPTR;
      S_BPTR:  state_nxt = S_BENT;
      S_BENT:  state_nxt = (kx_r >= be_r) ? S_BLOOK : S_BCHK;
      S_BCHK:  state_nxt = (32'(b_ent_row) >= 32'(kd_eff)) ? S_BENT : S_APTR;
      S_APTR:  state_nxt = S_ARD;
      S_ARD:   state_nxt = (ix_r >= ae_r) ? S_BENT : S_ACHK;
      S_ACHK:  state_nxt = (32'(a_ent_row) >= 32'(m_eff)) ? S_ARD : S_ACC;
      S_ACC:   state_nxt = S_ARD;
      S_READ:  state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      a_rows_r    <= CFG_RESET;
      inner_dim_r <= CFG_RESET;
      b_cols_r    <= CFG_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_A_ROWS:    a_rows_r    <= cfg_data;
          CFG_INNER_DIM: inner_dim_r <= cfg_data;
          CFG_B_COLS:    b_cols_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else begin
      case (state_r)
        S_INIT: clr_addr_r <= clr_addr_r + PS_AW'(1);
        S_IDLE: begin
          clr_addr_r   <= '0;
          out_value_r  <= '0;
          out_status_r <= (in_kind == KIND_READ && rd_bad) ? ST_RANGE : ST_OK;
        end
        S_LOAD: begin
          if (a_rsp.done) begin
            out_status_r <= a_rsp.status;
          end else if (b_rsp.done) begin
            out_status_r <= b_rsp.status;
          end
        end
        S_PCLR: begin
          clr_addr_r <= clr_addr_r + PS_AW'(1);
          j_r        <= '0;
        end
        S_BPTR: begin
          kx_r <= b_ptr_lo;
          be_r <= b_ptr_hi;
        end
        S_BENT: if (kx_r >= be_r) j_r <= j_r + DW'(1);
        S_BCHK: begin
          kx_r <= kx_r + CW'(1);
          bv_r <= b_ent_value;
        end
        S_APTR: begin
          ix_r <= a_ptr_lo;
          ae_r <= a_ptr_hi;
        end
        S_ACHK: begin
          ix_r       <= ix_r + CW'(1);
          prod_r     <= a_ent_value * bv_r;
          ps_waddr_r <= ps_raddr;
        end
        S_READ: out_value_r <= ps_rd_r;
        default: ;
      endcase
    end
  end

  // The sweep after reset and the one at the start of a compute share the write port.
  always_ff @(posedge clk) begin
    if (state_r == S_PCLR || state_r == S_INIT) begin
      ps_mem[clr_addr_r] <= '0;
    end else if (state_r == S_ACC) begin
      ps_mem[ps_waddr_r] <= ps_rd_r + ACC_W'(prod_r);
    end
    ps_rd_r <= ps_mem[ps_raddr];
  end

  `ASSERT_ALWAYS(a_one_side, clk, rst_n, !(in_ready && out_valid), "ready while result pending")
  `ASSERT_IMPLIES(a_err_zero, clk, rst_n, out_valid && (out_status != ST_OK), out_product_value == '0, "nonzero value with error status")
  `ASSERT_IMPLIES(a_acc_col, clk, rst_n, state_r == S_ACC, 32'(j_r) < 32'(n_eff), "accumulate outside product columns")

endmodule

// File: tb/sv/sparse_csc_matrix_multiply_core_tb.sv
// Testbench for the sparse matrix multiply core, checked against its own prediction model.
`timescale 1ns / 1ps

module sparse_csc_matrix_multiply_core_tb;
  import smm_pkg::*;

  localparam int DIM       = MAX_DIM_DEF;
  localparam int NNZ       = MAX_NNZ_DEF;
  localparam int LIMIT     = 8000000;
  localparam int ITEMS     = 1150;
  localparam int HOLD_AT   = 300;
  localparam int HOLD_LEN  = 600;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [ACC_W-1:0] value;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [IDX_W-1:0] in_row = '0;
  logic [IDX_W-1:0] in_col = '0;
  logic signed [VAL_W-1:0] in_entry_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic signed [ACC_W-1:0] out_product_value;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  sparse_csc_matrix_multiply_core dut (.*);

  always #5 clk = ~clk;

  // Mirror of the block's matrices, product store and dimensions.
  logic [8:0]              m_a_start [DIM+1];
  logic [IDX_W-1:0]        m_a_row   [NNZ];
  logic signed [VAL_W-1:0] m_a_val   [NNZ];
  int unsigned             m_a_count, m_a_last;
  logic [8:0]              m_b_start [DIM+1];
  logic [IDX_W-1:0]        m_b_row   [NNZ];
  logic signed [VAL_W-1:0] m_b_val   [NNZ];
  int unsigned             m_b_count, m_b_last;
  logic [ACC_W-1:0]        m_prod    [DIM*DIM];
  logic [CFG_W-1:0]        m_dim     [3];

  request_t pending_q[$];
  answer_t  expected_q[$];
  request_t cur_req;
  int       mismatches = 0;
  int       issued = 0;
  int       received = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  bit       steady = 1'b0;
  bit       held_off = 1'b0;
  int unsigned cycles = 0;

  function automatic int unsigned eff(logic [CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return d;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic model_clear();
    for (int j = 0; j <= DIM; j++) begin
      m_a_start[j] = '0;
      m_b_start[j] = '0;
    end
    m_a_count = 0; m_a_last = 0;
    m_b_count = 0; m_b_last = 0;
  endtask

  task automatic model_compute();
    int unsigned m, kd, n, k, i;
    logic signed [31:0] p;
    m = eff(m_dim[CFG_A_ROWS]);
    kd = eff(m_dim[CFG_INNER_DIM]);
    n = eff(m_dim[CFG_B_COLS]);
    for (int x = 0; x < DIM*DIM; x++) m_prod[x] = '0;
    for (int j = 0; j < n; j++) begin
      for (int kx = m_b_start[j]; kx < m_b_start[j+1] && kx < NNZ; kx++) begin
        k = m_b_row[kx];
        if (k < kd) begin
          for (int ix = m_a_start[k]; ix < m_a_start[k+1] && ix < NNZ; ix++) begin
            i = m_a_row[ix];
            if (i < m) begin
              p = m_a_val[ix] * m_b_val[kx];
              m_prod[i*DIM+j] = m_prod[i*DIM+j] + {{(ACC_W-32){p[31]}}, p};
            end
          end
        end
      end
    end
  endtask

  // Works out the answer to one accepted request and updates the mirror.
  task automatic predict_answer(request_t rq);
    answer_t an;
    int unsigned rows, cols;
    bit is_a;
    an = '{status: ST_OK, value: '0};
    case (rq.kind)
      KIND_LOAD_A, KIND_LOAD_B: begin
        is_a = (rq.kind == KIND_LOAD_A);
        rows = is_a ? eff(m_dim[CFG_A_ROWS]) : eff(m_dim[CFG_INNER_DIM]);
        cols = is_a ? eff(m_dim[CFG_INNER_DIM]) : eff(m_dim[CFG_B_COLS]);
        if (rq.row >= rows || rq.col >= cols) an.status = ST_RANGE;
        else if (rq.col < (is_a ? m_a_last : m_b_last)) an.status = ST_ORDER;
        else if ((is_a ? m_a_count : m_b_count) >= NNZ) an.status = ST_FULL;
        else if (is_a) begin
          m_a_row[m_a_count] = rq.row;
          m_a_val[m_a_count] = rq.value;
          m_a_count++;
          m_a_last = rq.col;
          for (int j = rq.col + 1; j <= DIM; j++) m_a_start[j] = 9'(m_a_count);
        end else begin
          m_b_row[m_b_count] = rq.row;
          m_b_val[m_b_count] = rq.value;
          m_b_count++;
          m_b_last = rq.col;
          for (int j = rq.col + 1; j <= DIM; j++) m_b_start[j] = 9'(m_b_count);
        end
      end
      KIND_COMPUTE: model_compute();
      KIND_READ: begin
        if (rq.row >= eff(m_dim[CFG_A_ROWS]) || rq.col >= eff(m_dim[CFG_B_COLS]))
          an.status = ST_RANGE;
        else an.value = m_prod[rq.row*DIM+rq.col];
      end
      KIND_CLEAR: model_clear();
      default: ;
    endcase
    expected_q = {expected_q, an};
  endtask

  // Driver: offers queued requests with random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_answer(cur_req);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_req = pending_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= cur_req.kind;
          in_row <= cur_req.row;
          in_col <= cur_req.col;
          in_entry_value <= cur_req.value;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk) begin
    answer_t ex;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        received++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d value %0d", out_status, out_product_value);
        end else begin
          ex = expected_q.pop_front();
          if (ex.status !== out_status || ex.value !== out_product_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d value %0d, got status %0d value %0d",
                       ex.status, ex.value, out_status, out_product_value);
          end
        end
      end
      // One long hold-off so that the core stalls its input.
      if (!held_off && received >= HOLD_AT) begin
        held_off = 1'b1;
        recv_gap = HOLD_LEN;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_req(int k, int r, int c, int v);
    request_t rq;
    rq.kind = k[KIND_W-1:0];
    rq.row = r[IDX_W-1:0];
    rq.col = c[IDX_W-1:0];
    rq.value = v[VAL_W-1:0];
    pending_q = {pending_q, rq};
    issued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    m_dim[idx] = val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_q.size() > 0 || in_valid || expected_q.size() > 0);
    repeat (5) @(posedge clk);
  endtask

  // Loads n entries of one matrix in mostly ascending column order.
  task automatic queue_loads(int k, int n, int rows, int cols);
    int c, r;
    c = 0;
    for (int e = 0; e < n; e++) begin
      if ($urandom_range(0, 3) == 0 && c < cols - 1) c += $urandom_range(1, 3);
      if (c > cols - 1) c = cols - 1;
      r = $urandom_range(0, rows - 1);
      case ($urandom_range(0, 19))
        0: queue_req(k, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
        1: queue_req(k, r, (c > 0) ? c - 1 : 0, $urandom);
        default: queue_req(k, r, c, $urandom);
      endcase
    end
  endtask

  task automatic queue_session();
    int ar, id, bc;
    ar = eff(m_dim[CFG_A_ROWS]);
    id = eff(m_dim[CFG_INNER_DIM]);
    bc = eff(m_dim[CFG_B_COLS]);
    queue_req(KIND_CLEAR, $urandom, $urandom, $urandom);
    queue_loads(KIND_LOAD_A, $urandom_range(1, 24), ar, id);
    queue_loads(KIND_LOAD_B, $urandom_range(1, 24), id, bc);
    if ($urandom_range(0, 3) == 0) queue_req($urandom_range(0, 7), $urandom, $urandom, $urandom);
    queue_req(KIND_COMPUTE, $urandom, $urandom, $urandom);
    for (int q = 0; q < 20; q++) begin
      if ($urandom_range(0, 9) == 0)
        queue_req($urandom_range(0, 7), $urandom, $urandom, $urandom);
      else
        queue_req(KIND_READ, $urandom_range(0, ar - 1), $urandom_range(0, bc - 1), $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 3; i++) m_dim[i] = CFG_RESET;
    for (int x = 0; x < DIM*DIM; x++) m_prod[x] = '0;
    model_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, ordering, range and duplicate cases on a small shape.
    write_reg(CFG_A_ROWS, 4);
    write_reg(CFG_INNER_DIM, 3);
    write_reg(CFG_B_COLS, 2);
    queue_req(KIND_LOAD_A, 0, 0, -32768);
    queue_req(KIND_LOAD_A, 3, 0, 32767);
    queue_req(KIND_LOAD_A, 3, 0, 256);
    queue_req(KIND_LOAD_A, 1, 2, -1);
    queue_req(KIND_LOAD_A, 2, 1, 5);
    queue_req(KIND_LOAD_A, 4, 2, 7);
    queue_req(KIND_LOAD_A, 0, 3, 7);
    queue_req(KIND_LOAD_B, 0, 0, -32768);
    queue_req(KIND_LOAD_B, 2, 1, 32767);
    queue_req(KIND_LOAD_B, 1, 0, 9);
    queue_req(KIND_LOAD_B, 3, 1, 1);
    queue_req(KIND_COMPUTE, 31, 31, -1);
    queue_req(KIND_READ, 0, 0, 0);
    queue_req(KIND_READ, 3, 0, 0);
    queue_req(KIND_READ, 1, 1, 0);
    queue_req(KIND_READ, 3, 1, 0);
    queue_req(KIND_READ, 4, 0, 0);
    queue_req(KIND_READ, 0, 2, 0);
    queue_req(KIND_CLEAR + 1, 31, 31, -1);
    queue_req(KIND_CLEAR + 2, 0, 0, 0);
    queue_req(KIND_CLEAR + 3, 31, 0, 32767);
    wait_idle();
    // Shrinking the shape after loading makes the compute skip stored entries.
    write_reg(CFG_A_ROWS, 1);
    write_reg(CFG_INNER_DIM, 1);
    queue_req(KIND_COMPUTE, 0, 0, 0);
    queue_req(KIND_READ, 0, 0, 0);
    queue_req(KIND_CLEAR, 0, 0, 0);
    queue_req(KIND_READ, 0, 0, 0);
    wait_idle();

    // Zero and oversized dimensions.
    write_reg(CFG_A_ROWS, 0);
    write_reg(CFG_INNER_DIM, 63);
    write_reg(CFG_B_COLS, 0);
    queue_session();
    wait_idle();

    // Fill A to capacity at full size, then multiply with a thin B.
    steady = 1'b1;
    write_reg(CFG_A_ROWS, 32);
    write_reg(CFG_INNER_DIM, 32);
    write_reg(CFG_B_COLS, 32);
    queue_req(KIND_CLEAR, 0, 0, 0);
    for (int e = 0; e < NNZ + 4; e++) queue_req(KIND_LOAD_A, $urandom, e / 8, $urandom);
    for (int e = 0; e < 6; e++) queue_req(KIND_LOAD_B, $urandom, 5 * e, $urandom);
    queue_req(KIND_COMPUTE, 0, 0, 0);
    for (int q = 0; q < 10; q++) queue_req(KIND_READ, $urandom, 5 * $urandom_range(0, 6), 0);
    wait_idle();
    steady = 1'b0;

    while (issued < ITEMS) begin
      write_reg(CFG_A_ROWS, $urandom_range(0, 63));
      write_reg(CFG_INNER_DIM, $urandom_range(0, 40));
      write_reg(CFG_B_COLS, $urandom_range(1, 33));
      steady = ($urandom_range(0, 4) == 0);
      queue_session();
      queue_session();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/smm_pkg.sv
design/smm_csc_store.sv
design/sparse_csc_matrix_multiply_core.sv
tb/sv/sparse_csc_matrix_multiply_core_tb.sv
